FILE: rtl/core/bfe_pkg.sv
// Shared types and constants for the 3x3 edge-clipped box filter.
// No dependencies; used by every file in rtl/core.
package bfe_pkg;

    localparam int AVG_BITS   = 20;
    localparam int CFG_BITS   = 11;
    localparam int ROW_BITS   = 11;
    localparam int MAX_HEIGHT = 1024;
    localparam int FIFO_DEPTH = 4;

    typedef logic [AVG_BITS-1:0] t_avg;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } t_div_kind;

    typedef struct packed {
        t_avg average;
        logic changed;
        logic last_of_run;
        logic end_of_frame;
        logic frame_changed;
    } t_result;

endpackage

FILE: rtl/core/bfe_div.sv
// Two-stage exact divide of a window sum by 4, 6 or 9 via reciprocal multiply.
// Depends on bfe_pkg (t_div_kind).
module bfe_div #(
    parameter int SUM_BITS = 24,
    parameter int Q_BITS   = 20
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SUM_BITS-1:0]    i_sum,
    input  bfe_pkg::t_div_kind     i_kind,
    output logic [Q_BITS-1:0]      o_quot
);

    localparam int LO_BITS   = (SUM_BITS + 1) / 2;
    localparam int HI_BITS   = SUM_BITS - LO_BITS;
    localparam int M_BITS    = SUM_BITS + 1;
    localparam int HP_BITS   = HI_BITS + M_BITS;
    localparam int LP_BITS   = LO_BITS + M_BITS;
    localparam int FULL_BITS = 2 * SUM_BITS + 1;

    // ceil(2^(N+L)/d) with L = ceil(log2 d): exact for every N-bit sum
    localparam logic [63:0] M4_L = 64'd1 << SUM_BITS;
    localparam logic [63:0] M6_L = ((64'd1 << (SUM_BITS + 3)) + 64'd5) / 64'd6;
    localparam logic [63:0] M9_L = ((64'd1 << (SUM_BITS + 4)) + 64'd8) / 64'd9;
    localparam logic [M_BITS-1:0] M4 = M4_L[M_BITS-1:0];
    localparam logic [M_BITS-1:0] M6 = M6_L[M_BITS-1:0];
    localparam logic [M_BITS-1:0] M9 = M9_L[M_BITS-1:0];

    logic [M_BITS-1:0]    recip;
    logic [HP_BITS-1:0]   hi_prod;
    logic [LP_BITS-1:0]   lo_prod;
    logic [HP_BITS-1:0]   r_hi_prod;
    logic [LP_BITS-1:0]   r_lo_prod;
    bfe_pkg::t_div_kind   r_kind;
    logic [FULL_BITS-1:0] full;
    logic [FULL_BITS-1:0] shifted;

    always_comb begin
        case (i_kind)
            bfe_pkg::DIV_BY_4: recip = M4;
            bfe_pkg::DIV_BY_6: recip = M6;
            default:           recip = M9;
        endcase
    end

    assign hi_prod = HP_BITS'(i_sum[SUM_BITS-1:LO_BITS]) * HP_BITS'(recip);
    assign lo_prod = LP_BITS'(i_sum[LO_BITS-1:0]) * LP_BITS'(recip);

    assign full = {r_hi_prod, {LO_BITS{1'b0}}} + FULL_BITS'(r_lo_prod);

    always_comb begin
        case (r_kind)
            bfe_pkg::DIV_BY_4: shifted = full >> (SUM_BITS + 2);
            bfe_pkg::DIV_BY_6: shifted = full >> (SUM_BITS + 3);
            default:           shifted = full >> (SUM_BITS + 4);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi_prod <= hi_prod;
            r_lo_prod <= lo_prod;
            r_kind    <= i_kind;
            o_quot    <= Q_BITS'(shifted);
        end
    end

endmodule

FILE: rtl/core/bfe_out_fifo.sv
// Four-entry result queue taking up to two results per cycle, one out.
// Depends on bfe_pkg (t_result, FIFO_DEPTH).
module bfe_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_a,
    input  logic             i_push_b,
    input  bfe_pkg::t_result i_res_a,
    input  bfe_pkg::t_result i_res_b,
    input  logic             i_pop,
    output logic             o_valid,
    output bfe_pkg::t_result o_head,
    output logic             o_room
);

    localparam int PTR_BITS = $clog2(bfe_pkg::FIFO_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    bfe_pkg::t_result      r_slot [bfe_pkg::FIFO_DEPTH];
    logic [PTR_BITS-1:0]   r_wp;
    logic [PTR_BITS-1:0]   r_rp;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic [PTR_BITS-1:0]   wp_next;

    assign wp_next = r_wp + PTR_BITS'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rp];
    assign o_room  = (r_count <= CNT_BITS'(bfe_pkg::FIFO_DEPTH - 2));

    always_comb begin
        n_count = r_count + CNT_BITS'(i_push_a) + CNT_BITS'(i_push_b)
                  - CNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_pop) begin
                r_rp <= r_rp + PTR_BITS'(1);
            end
            if (i_push_b) begin
                r_wp <= r_wp + PTR_BITS'(2);
            end else if (i_push_a) begin
                r_wp <= wp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_slot[r_wp] <= i_res_a;
        end
        if (i_push_b) begin
            r_slot[wp_next] <= i_res_b;
        end
    end

endmodule

FILE: rtl/core/box_filter_3x3_edge_mean_top.sv
// Streaming 3x3 box filter with edge-clipped mean: line memory, window, sums.
// Depends on bfe_pkg, bfe_div and bfe_out_fifo.
//
// One pixel request is taken per clock while the output queue has room. The
// pixel in the last column of a row yields two results and the column 0 pixel
// yields none, while the output queue drains one per clock when the sink does
// not stall. The line memory (MAX_WIDTH words holding the upper and middle
// lines) gets one read and one write per cycle. Results lag one row and one
// column; a frame of H rows is followed by one drain row of W requests whose
// pixel field is ignored. The role of a request follows from the position
// counters only. A write to either register restarts the frame position. No
// clearing pass after reset.
module box_filter_3x3_edge_mean_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [PIXEL_BITS-1:0]         i_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bfe_pkg::AVG_BITS-1:0]  o_average,
    output logic                          o_changed,
    output logic                          o_last_of_run,
    output logic                          o_end_of_frame,
    output logic                          o_frame_changed
);

    localparam int P        = PIXEL_BITS;
    localparam int CS_BITS  = P + 2;
    localparam int SUM_BITS = P + 4;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CMP_BITS = (COL_BITS >= 11) ? COL_BITS + 1 : 12;
    localparam int CFG_W    = bfe_pkg::CFG_BITS;
    localparam int ROW_W    = bfe_pkg::ROW_BITS;
    localparam logic [CFG_W-1:0] WIDTH_RESET =
        (MAX_WIDTH < 1024) ? CFG_W'(MAX_WIDTH) : CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(bfe_pkg::MAX_HEIGHT);

    typedef struct packed {
        logic has_res;
        logic top_excl;
        logic drain;
        logic c_ge2;
        logic last;
    } t_meta;

    // configuration
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_val;
    logic [CFG_W-1:0] width_clamped;
    logic [CFG_W-1:0] height_clamped;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // position and control
    logic                en;
    logic                accept;
    logic [COL_BITS-1:0] r_col;
    logic [ROW_W-1:0]    r_row;
    logic [COL_BITS-1:0] n_col;
    logic [ROW_W-1:0]    n_row;
    logic [CMP_BITS-1:0] col_inc;
    t_meta               meta_in;
    logic [P-1:0]        bot_in;
    logic                r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic                r_any;

    // datapath
    logic [2*P-1:0]      r_line [MAX_WIDTH];
    logic [2*P-1:0]      r_rd;
    logic [COL_BITS-1:0] r_col1;
    logic [P-1:0]        r_bot1;
    t_meta               r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic [P-1:0]        r_win [3][3];
    logic [CS_BITS-1:0]  col_sum [3];
    logic [CS_BITS-1:0]  r_cs [3];
    logic [P-1:0]        r_ctr_a3, r_ctr_a4, r_ctr_a5, r_ctr_a6;
    logic [P-1:0]        r_ctr_b3, r_ctr_b4, r_ctr_b5, r_ctr_b6;
    logic [SUM_BITS-1:0] sum_a;
    logic [SUM_BITS-1:0] sum_b;
    logic [SUM_BITS-1:0] r_sum_a4;
    logic [SUM_BITS-1:0] r_sum_b4;
    bfe_pkg::t_div_kind  kind_a;
    bfe_pkg::t_div_kind  kind_b;
    bfe_pkg::t_div_kind  r_kind_a4;
    bfe_pkg::t_div_kind  r_kind_b4;
    logic [P-1:0]        quot_a;
    logic [P-1:0]        quot_b;

    // result assembly
    logic             ch_a;
    logic             ch_b;
    logic             eof;
    logic             push_a;
    logic             push_b;
    logic             pop;
    logic             room;
    bfe_pkg::t_result res_a;
    bfe_pkg::t_result res_b;
    bfe_pkg::t_result head;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_val = pwdata[CFG_W-1:0];

    always_comb begin
        if (cfg_val < CFG_W'(2)) begin
            width_clamped  = CFG_W'(2);
            height_clamped = CFG_W'(2);
        end else begin
            width_clamped  = cfg_val;
            height_clamped = cfg_val;
            if (CMP_BITS'(cfg_val) > CMP_BITS'(MAX_WIDTH)) begin
                width_clamped = CFG_W'(MAX_WIDTH);
            end
            if (cfg_val > HEIGHT_RESET) begin
                height_clamped = HEIGHT_RESET;
            end
        end
    end

    always_comb begin
        case (bfe_pkg::t_reg_idx'(paddr[2]))
            bfe_pkg::REG_WIDTH:  prdata = 32'(r_width);
            bfe_pkg::REG_HEIGHT: prdata = 32'(r_height);
            default:             prdata = '0;
        endcase
    end

    // ---------------- position counters ----------------
    assign en         = room;
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;

    assign col_inc          = CMP_BITS'(r_col) + CMP_BITS'(1);
    assign meta_in.last     = (col_inc >= CMP_BITS'(r_width));
    assign meta_in.drain    = (CFG_W'(r_row) >= r_height);
    assign meta_in.has_res  = (r_row != '0) && (r_col != '0);
    assign meta_in.top_excl = (r_row == ROW_W'(1));
    assign meta_in.c_ge2    = (CMP_BITS'(r_col) >= CMP_BITS'(2));
    assign bot_in           = meta_in.drain ? '0 : i_pixel;

    always_comb begin
        n_col = r_col + COL_BITS'(1);
        n_row = r_row;
        if (meta_in.last) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
            if (CFG_W'(n_row) > r_height) begin
                n_row = '0;
            end
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_any    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
        end else begin
            if (en) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                r_v6 <= r_v5;
            end
            if (cfg_wr) begin
                case (bfe_pkg::t_reg_idx'(paddr[2]))
                    bfe_pkg::REG_WIDTH:  r_width  <= width_clamped;
                    bfe_pkg::REG_HEIGHT: r_height <= height_clamped;
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
                r_any <= 1'b0;
            end else begin
                if (accept) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end
                if (push_a) begin
                    if (eof) begin
                        r_any <= 1'b0;
                    end else begin
                        r_any <= r_any | ch_a | (push_b & ch_b);
                    end
                end
            end
        end
    end

    // ---------------- line memory: {upper, middle} per column ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col];
        end
        if (en && r_v1) begin
            r_line[r_col1] <= {r_rd[P-1:0], r_bot1};
        end
    end

    // ---------------- window and sums ----------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            col_sum[k] = (r_m2.top_excl ? '0 : CS_BITS'(r_win[0][k]))
                       + CS_BITS'(r_win[1][k])
                       + (r_m2.drain ? '0 : CS_BITS'(r_win[2][k]));
        end
    end

    assign sum_b = SUM_BITS'(r_cs[1]) + SUM_BITS'(r_cs[2]);
    assign sum_a = sum_b + (r_m3.c_ge2 ? SUM_BITS'(r_cs[0]) : '0);

    always_comb begin
        logic rows3;
        rows3 = !r_m3.top_excl && !r_m3.drain;
        if (rows3 && r_m3.c_ge2) begin
            kind_a = bfe_pkg::DIV_BY_9;
        end else if (rows3 || r_m3.c_ge2) begin
            kind_a = bfe_pkg::DIV_BY_6;
        end else begin
            kind_a = bfe_pkg::DIV_BY_4;
        end
        kind_b = rows3 ? bfe_pkg::DIV_BY_6 : bfe_pkg::DIV_BY_4;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1   <= meta_in;
            r_col1 <= r_col;
            r_bot1 <= bot_in;

            r_m2 <= r_m1;
            if (r_v1) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= r_rd[2*P-1:P];
                r_win[1][2] <= r_rd[P-1:0];
                r_win[2][2] <= r_bot1;
            end

            r_m3     <= r_m2;
            r_cs     <= col_sum;
            r_ctr_a3 <= r_win[1][1];
            r_ctr_b3 <= r_win[1][2];

            r_m4      <= r_m3;
            r_sum_a4  <= sum_a;
            r_sum_b4  <= sum_b;
            r_kind_a4 <= kind_a;
            r_kind_b4 <= kind_b;
            r_ctr_a4  <= r_ctr_a3;
            r_ctr_b4  <= r_ctr_b3;

            r_m5     <= r_m4;
            r_ctr_a5 <= r_ctr_a4;
            r_ctr_b5 <= r_ctr_b4;

            r_m6     <= r_m5;
            r_ctr_a6 <= r_ctr_a5;
            r_ctr_b6 <= r_ctr_b5;
        end
    end

    bfe_div #(
        .SUM_BITS (SUM_BITS),
        .Q_BITS   (P)
    ) u_div_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum_a4),
        .i_kind (r_kind_a4),
        .o_quot (quot_a)
    );

    bfe_div #(
        .SUM_BITS (SUM_BITS),
        .Q_BITS   (P)
    ) u_div_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r_sum_b4),
        .i_kind (r_kind_b4),
        .o_quot (quot_b)
    );

    // ---------------- result assembly ----------------
    assign ch_a   = (quot_a != r_ctr_a6);
    assign ch_b   = (quot_b != r_ctr_b6);
    assign push_a = en && r_v6 && r_m6.has_res;
    assign push_b = push_a && r_m6.last;
    assign eof    = push_b && r_m6.drain;

    always_comb begin
        res_a.average       = bfe_pkg::t_avg'(quot_a);
        res_a.changed       = ch_a;
        res_a.last_of_run   = !r_m6.last;
        res_a.end_of_frame  = 1'b0;
        res_a.frame_changed = 1'b0;

        res_b.average       = bfe_pkg::t_avg'(quot_b);
        res_b.changed       = ch_b;
        res_b.last_of_run   = 1'b1;
        res_b.end_of_frame  = r_m6.drain;
        res_b.frame_changed = r_m6.drain & (r_any | ch_a | ch_b);
    end

    assign pop = o_out_valid && !i_out_stall;

    bfe_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_push_b (push_b),
        .i_res_a  (res_a),
        .i_res_b  (res_b),
        .i_pop    (pop),
        .o_valid  (o_out_valid),
        .o_head   (head),
        .o_room   (room)
    );

    assign o_average       = head.average;
    assign o_changed       = head.changed;
    assign o_last_of_run   = head.last_of_run;
    assign o_end_of_frame  = head.end_of_frame;
    assign o_frame_changed = head.frame_changed;

endmodule

FILE: rtl/core/bfe_checker.sv
// Port-level checks for the box filter top level, bound to every instance.
// Depends on box_filter_3x3_edge_mean_top and bfe_pkg.
module bfe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [bfe_pkg::AVG_BITS-1:0] o_average,
    input logic                         o_changed,
    input logic                         o_last_of_run,
    input logic                         o_end_of_frame,
    input logic                         o_frame_changed
);

    // a result request held by the sink keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_average)
        && $stable(o_changed) && $stable(o_last_of_run)
        && $stable(o_end_of_frame) && $stable(o_frame_changed))
        else $error("result payload moved while stalled");

    a_fc_on_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_changed |-> o_end_of_frame)
        else $error("frame_changed outside end of frame");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame not last of its run");

    a_eof_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame && o_changed |-> o_frame_changed)
        else $error("changed bottom-right pixel not reported for frame");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request after reset");

endmodule

bind box_filter_3x3_edge_mean_top bfe_checker u_bfe_checker (.*);
